// ===== sv/pa3_pkg.sv =====
// Shared types and constants for the 3D polygon vector-area block.
// Used by polygon_area_3d; depends on nothing else.
`default_nettype none

package pa3_pkg;

  localparam int SUM_W      = 47;          // cross-product accumulator width
  localparam int CNT_OUT_W  = 7;           // reported vertex count width
  localparam int OUT_W      = 56;          // packed result width, whole bytes
  localparam int LIMB_LO    = 24;          // low limb of an accumulator when squaring
  localparam int LIMB_HI    = SUM_W - LIMB_LO;
  localparam int NORM_W     = 96;          // sum of three squares
  localparam int ROOT_W     = NORM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int ROOT_STEPS = ROOT_W;      // one result bit per cycle
  localparam int STEP_W     = 6;
  localparam int CROSS_TERMS  = 6;
  localparam int SQUARE_TERMS = 9;
  localparam int SH_MID_AMT = LIMB_LO + 1; // 2*hi*lo term
  localparam int SH_HI_AMT  = 2 * LIMB_LO;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SH_HI,
    SH_MID,
    SH_LO
  } shk_e;

  // what to do with the registered product in the next cycle
  typedef struct packed {
    logic       valid;
    logic       sq;
    logic [1:0] idx;
    logic       neg;
    shk_e       shk;
  } acc_op_t;

endpackage

`default_nettype wire

// ===== sv/polygon_area_3d.sv =====
// Vector area of a closed 3D polygon: one shared multiplier, accumulators and
// a digit-recurrence square root under a small sequencer. Depends on pa3_pkg.
//
// Usage:
//   Slave channel: one vertex per transaction. tdata holds x, y, z (signed,
//   COORD_BITS each), tlast marks the closing vertex of the polygon.
//   Master channel: one result per polygon, sent after the closing vertex.
//   tdata holds area_half_mm2 (47b), vertex_count (7b), too_many (1b).
//   Sequence: each vertex after the first runs six products through the
//   shared multiplier and keeps s_axis_tready_o low until they are
//   accumulated; a first or dropped vertex that does not close the polygon
//   leaves it high. The closing vertex runs its own cross term (if it was
//   counted and is not the first), then the closing term, squares the three
//   accumulators in split limbs and takes the square root (one root bit per
//   cycle), then loads the output; below three vertices the squares and the
//   root are skipped.
//   Stall: the result sits in an output register; new vertices are taken
//   while it waits, and only the next closing vertex waits for it to drain.
//   Reset: clears accumulators, vertex count and overflow flag; no result
//   is pending afterwards.
`default_nettype none

module polygon_area_3d #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // vertex_x, vertex_y, vertex_z from bit 0 up, zero padded to bytes
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic s_axis_tlast_i,        // last_vertex
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // area_half_mm2 [46:0], vertex_count [53:47], too_many [54], pad [55]
  output logic [pa3_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int OPW = (COORD_BITS > pa3_pkg::LIMB_LO + 1) ? COORD_BITS
                                                            : pa3_pkg::LIMB_LO + 1;
  localparam int PW  = 2 * OPW;
  localparam int SW  = pa3_pkg::SUM_W;
  localparam int NW  = pa3_pkg::NORM_W;
  localparam int RW  = pa3_pkg::ROOT_W;
  localparam int MW  = pa3_pkg::REM_W;

  pa3_pkg::state_e state_q, state_d;
  logic [pa3_pkg::STEP_W-1:0] step_q, step_d;
  logic pass_q, pass_d;     // 0: previous x current, 1: closing term
  logic close_q, close_d;

  logic signed [COORD_BITS-1:0] cur_q [3], cur_d [3];
  logic signed [COORD_BITS-1:0] first_q [3], first_d [3];
  logic signed [COORD_BITS-1:0] prev_q [3], prev_d [3];
  logic [SW-1:0] sum_q [3], sum_d [3];
  logic [CW-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;

  logic signed [PW-1:0] prod_q, prod_d;
  pa3_pkg::acc_op_t op_q, op_d;
  logic [NW-1:0] norm_q, norm_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;

  logic out_valid_q, out_valid_d;
  logic [SW-1:0] out_area_q, out_area_d;
  logic [pa3_pkg::CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;
  logic out_ovf_q, out_ovf_d;

  // combinational helpers
  logic signed [COORD_BITS-1:0] in_c [3];
  logic signed [OPW-1:0] mul_a, mul_b;
  logic [1:0] ai, bi, comp;
  pa3_pkg::shk_e kind;
  logic signed [COORD_BITS-1:0] op_av, op_bv;
  logic [SW-1:0] sq_src;
  logic signed [pa3_pkg::LIMB_HI-1:0] sq_hi;
  logic signed [pa3_pkg::LIMB_LO:0] sq_lo;
  logic signed [NW-1:0] pext, pshift;
  logic [SW-1:0] p_sum;
  logic [MW-1:0] rem_t, trial;
  logic [CW+pa3_pkg::CNT_OUT_W-1:0] cnt_wide;
  logic drop, issue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_c[i] = s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
    end
  end

  assign s_axis_tready_o = (state_q == pa3_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_ovf_q, out_cnt_q, out_area_q};

  // operand selection for the shared multiplier
  always_comb begin
    ai   = 2'd0;
    bi   = 2'd0;
    comp = 2'd0;
    kind = pa3_pkg::SH_LO;
    unique case (step_q[2:0])
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      3'd5:    begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
    unique case (step_q[3:0])
      4'd0:    begin comp = 2'd0; kind = pa3_pkg::SH_HI;  end
      4'd1:    begin comp = 2'd0; kind = pa3_pkg::SH_MID; end
      4'd2:    begin comp = 2'd0; kind = pa3_pkg::SH_LO;  end
      4'd3:    begin comp = 2'd1; kind = pa3_pkg::SH_HI;  end
      4'd4:    begin comp = 2'd1; kind = pa3_pkg::SH_MID; end
      4'd5:    begin comp = 2'd1; kind = pa3_pkg::SH_LO;  end
      4'd6:    begin comp = 2'd2; kind = pa3_pkg::SH_HI;  end
      4'd7:    begin comp = 2'd2; kind = pa3_pkg::SH_MID; end
      4'd8:    begin comp = 2'd2; kind = pa3_pkg::SH_LO;  end
      default: begin comp = 2'd0; kind = pa3_pkg::SH_LO;  end
    endcase

    op_av = prev_q[ai];
    op_bv = pass_q ? first_q[bi] : cur_q[bi];

    // signed hi limb, unsigned lo limb: s^2 = hi^2<<48 + 2*hi*lo<<24 + lo^2
    sq_src = sum_q[comp];
    sq_hi  = sq_src[SW-1:pa3_pkg::LIMB_LO];
    sq_lo  = {1'b0, sq_src[pa3_pkg::LIMB_LO-1:0]};

    if (state_q == pa3_pkg::ST_SQUARE) begin
      unique case (kind)
        pa3_pkg::SH_HI:  begin mul_a = OPW'(sq_hi); mul_b = OPW'(sq_hi); end
        pa3_pkg::SH_MID: begin mul_a = OPW'(sq_hi); mul_b = OPW'(sq_lo); end
        default:         begin mul_a = OPW'(sq_lo); mul_b = OPW'(sq_lo); end
      endcase
    end else begin
      mul_a = OPW'(op_av);
      mul_b = OPW'(op_bv);
    end
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pass_d      = pass_q;
    close_d     = close_q;
    cur_d       = cur_q;
    first_d     = first_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    norm_d      = norm_q;
    rem_d       = rem_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    out_area_d  = out_area_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;

    issue = ((state_q == pa3_pkg::ST_CROSS) &&
             (step_q < pa3_pkg::STEP_W'(pa3_pkg::CROSS_TERMS))) ||
            ((state_q == pa3_pkg::ST_SQUARE) &&
             (step_q < pa3_pkg::STEP_W'(pa3_pkg::SQUARE_TERMS)));
    op_d.valid = issue;
    op_d.sq    = (state_q == pa3_pkg::ST_SQUARE);
    op_d.idx   = (state_q == pa3_pkg::ST_SQUARE) ? comp : step_q[2:1];
    op_d.neg   = step_q[0];
    op_d.shk   = kind;

    // accumulate the product issued last cycle
    p_sum = prod_q[SW-1:0];
    pext  = NW'(prod_q);
    unique case (op_q.shk)
      pa3_pkg::SH_HI:  pshift = pext <<< pa3_pkg::SH_HI_AMT;
      pa3_pkg::SH_MID: pshift = pext <<< pa3_pkg::SH_MID_AMT;
      default:         pshift = pext;
    endcase
    if (op_q.valid) begin
      if (op_q.sq) begin
        norm_d = norm_q + NW'(pshift);
      end else if (op_q.neg) begin
        sum_d[op_q.idx] = sum_q[op_q.idx] - p_sum;
      end else begin
        sum_d[op_q.idx] = sum_q[op_q.idx] + p_sum;
      end
    end

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    drop = (cnt_q == CW'(MAX_VERTICES));

    // restoring square root step, two radicand bits per result bit
    rem_t = {rem_q[MW-3:0], norm_q[NW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};

    cnt_wide = (CW + pa3_pkg::CNT_OUT_W)'(cnt_q);

    unique case (state_q)
      pa3_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          step_d  = '0;
          close_d = s_axis_tlast_i;
          if (drop) begin
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              pass_d  = 1'b1;
              state_d = pa3_pkg::ST_CROSS;
            end
          end else begin
            cnt_d = cnt_q + CW'(1);
            cur_d = in_c;
            if (cnt_q == '0) begin
              first_d = in_c;
              prev_d  = in_c;
              if (s_axis_tlast_i) begin
                pass_d  = 1'b1;
                state_d = pa3_pkg::ST_CROSS;
              end
            end else begin
              pass_d  = 1'b0;
              state_d = pa3_pkg::ST_CROSS;
            end
          end
        end
      end

      pa3_pkg::ST_CROSS: begin
        step_d = step_q + pa3_pkg::STEP_W'(1);
        if (step_q == pa3_pkg::STEP_W'(pa3_pkg::CROSS_TERMS)) begin
          step_d = '0;
          if (!pass_q) begin
            prev_d = cur_q;
            if (close_q) begin
              pass_d = 1'b1;
            end else begin
              state_d = pa3_pkg::ST_IDLE;
            end
          end else if (cnt_q >= CW'(3)) begin
            norm_d  = '0;
            state_d = pa3_pkg::ST_SQUARE;
          end else begin
            state_d = pa3_pkg::ST_DONE;
          end
        end
      end

      pa3_pkg::ST_SQUARE: begin
        step_d = step_q + pa3_pkg::STEP_W'(1);
        if (step_q == pa3_pkg::STEP_W'(pa3_pkg::SQUARE_TERMS)) begin
          step_d  = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = pa3_pkg::ST_ROOT;
        end
      end

      pa3_pkg::ST_ROOT: begin
        step_d = step_q + pa3_pkg::STEP_W'(1);
        norm_d = norm_q << 2;
        if (rem_t >= trial) begin
          rem_d  = rem_t - trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = rem_t;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        if (step_q == pa3_pkg::STEP_W'(pa3_pkg::ROOT_STEPS - 1)) begin
          step_d  = '0;
          state_d = pa3_pkg::ST_DONE;
        end
      end

      pa3_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          if (cnt_q < CW'(3)) begin
            out_area_d = '0;
          end else if (root_q[RW-1:SW] != '0) begin
            out_area_d = '1;
          end else begin
            out_area_d = root_q[SW-1:0];
          end
          out_cnt_d = cnt_wide[pa3_pkg::CNT_OUT_W-1:0];
          out_ovf_d = ovf_q;
          for (int i = 0; i < 3; i++) begin
            sum_d[i]   = '0;
            first_d[i] = '0;
            prev_d[i]  = '0;
          end
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = pa3_pkg::ST_IDLE;
        end
      end

      default: state_d = pa3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pa3_pkg::ST_IDLE;
      step_q      <= '0;
      pass_q      <= 1'b0;
      close_q     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_q[i] <= '0;
        prev_q[i]  <= '0;
        sum_q[i]   <= '0;
      end
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      close_q     <= close_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prod_q     <= prod_d;
    norm_q     <= norm_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    out_area_q <= out_area_d;
    out_cnt_q  <= out_cnt_d;
    out_ovf_q  <= out_ovf_d;
  end

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == pa3_pkg::ST_DONE))
    else $error("result raised outside the done step");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_VERTICES))
    else $error("vertex count beyond maximum");

  a_drop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && cnt_q == CW'(MAX_VERTICES)) |=> ovf_q)
    else $error("dropped vertex did not set overflow");

  a_root_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pa3_pkg::ST_ROOT) |-> (step_q < pa3_pkg::STEP_W'(pa3_pkg::ROOT_STEPS)))
    else $error("square root ran past its last step");

endmodule

`default_nettype wire

// ===== bench/tb_polygon_area_3d.sv =====
`timescale 1ns / 1ps
// Self-checking bench for polygon_area_3d: streams closed 3D polygons and checks
// every reported area, vertex count and overflow flag against an inline predictor.
// Depends on pa3_pkg and polygon_area_3d.

module tb_polygon_area_3d;

  localparam int SUM_W        = pa3_pkg::SUM_W;
  localparam int CNT_OUT_W    = pa3_pkg::CNT_OUT_W;
  localparam int OUT_W        = pa3_pkg::OUT_W;
  localparam int MAX_VTX      = 64;
  localparam int COORD_W      = 20;
  localparam int IN_W         = ((3 * COORD_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [SUM_W-1:0] AREA_SAT = '1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;
  typedef struct packed {
    point_t pos;
    logic   closes;
  } vertex_t;
  typedef struct packed {
    logic [SUM_W-1:0]     area;
    logic [CNT_OUT_W-1:0] count;
    logic                 too_many;
  } area_result_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             vtx_valid = 1'b0;
  logic             vtx_ready;
  logic [IN_W-1:0]  vtx_data  = '0;
  logic             vtx_last  = 1'b0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  logic [OUT_W-1:0] res_data;

  vertex_t      vertex_queue[$];
  area_result_t area_expected[$];

  // predictor state
  point_t           first_pt = '0;
  point_t           prev_pt  = '0;
  logic [SUM_W-1:0] cross_acc[3] = '{default: '0};
  int unsigned      pts_held;
  bit               dropped;

  int          errors, vertices_in, total_queued, results_seen;
  int          polygons, thin_polygons, over_polygons;
  logic [SUM_W-1:0] max_area = '0;
  bit          vtx_taken, long_hold_done;
  int          vtx_gap, sink_hold;
  bit [31:0]   cycle_cnt;
  logic        steady;

  polygon_area_3d #(
    .MAX_VERTICES(MAX_VTX),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(vtx_valid),
    .s_axis_tready_o(vtx_ready),
    .s_axis_tdata_i (vtx_data),
    .s_axis_tlast_i (vtx_last),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_data)
  );

  always #10 clk_i = ~clk_i;

  // both sides run without idling for one stretch in four
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;
  assign steady = (cycle_cnt[11:10] == 2'b11);

  // ---------------------------------------------------------------- predictor
  function automatic void add_cross(point_t a, point_t b);
    longint ax, ay, az, bx, by, bz;
    longint term[3];
    logic [63:0] sum;
    ax = $signed(a.x);
    ay = $signed(a.y);
    az = $signed(a.z);
    bx = $signed(b.x);
    by = $signed(b.y);
    bz = $signed(b.z);
    term[0] = ay * bz - az * by;
    term[1] = az * bx - ax * bz;
    term[2] = ax * by - ay * bx;
    for (int i = 0; i < 3; i++) begin
      sum = 64'(cross_acc[i]) + 64'(term[i]);
      cross_acc[i] = sum[SUM_W-1:0];  // accumulators wrap at SUM_W bits
    end
  endfunction

  // floor of the Euclidean norm of the accumulators, saturated
  function automatic logic [SUM_W-1:0] area_from_sums();
    logic signed [SUM_W:0] wide;
    logic [SUM_W:0]        mag;
    logic [127:0]          norm_sq, cand_sq;
    logic [63:0]           root, cand;
    norm_sq = '0;
    for (int i = 0; i < 3; i++) begin
      wide = $signed(cross_acc[i]);
      mag = wide[SUM_W] ? -wide : wide;
      norm_sq += 128'(mag) * 128'(mag);
    end
    root = '0;
    for (int b = 48; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      cand_sq = 128'(cand) * 128'(cand);
      if (cand_sq <= norm_sq) root = cand;
    end
    return (root > 64'(AREA_SAT)) ? AREA_SAT : root[SUM_W-1:0];
  endfunction

  function automatic bit take_vertex(vertex_t v, output area_result_t res);
    res = '0;
    if (pts_held >= MAX_VTX) begin
      // vertex dropped; a dropped closing vertex closes with the kept ones
      dropped = 1'b1;
      if (v.closes) add_cross(prev_pt, first_pt);
    end else begin
      if (pts_held == 0) first_pt = v.pos;
      else add_cross(prev_pt, v.pos);
      prev_pt = v.pos;
      pts_held++;
      if (v.closes) add_cross(v.pos, first_pt);
    end
    if (!v.closes) return 1'b0;
    res.area     = (pts_held >= 3) ? area_from_sums() : '0;
    res.count    = pts_held[CNT_OUT_W-1:0];
    res.too_many = dropped;
    polygons++;
    if (pts_held < 3) thin_polygons++;
    if (dropped) over_polygons++;
    if (res.area > max_area) max_area = res.area;
    first_pt = '0;
    prev_pt  = '0;
    for (int i = 0; i < 3; i++) cross_acc[i] = '0;
    pts_held = 0;
    dropped  = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_pt(int x, int y, int z, bit closes);
    vertex_t v;
    v.pos.x  = coord_t'(x);
    v.pos.y  = coord_t'(y);
    v.pos.z  = coord_t'(z);
    v.closes = closes;
    vertex_queue.insert(vertex_queue.size(), v);
  endfunction

  function automatic coord_t pick_coord(int style);
    int v;
    if (style == 3) style = $urandom_range(0, 2);
    case (style)
      0: return coord_t'($urandom());
      1: begin
        v = $urandom_range(0, 200);
        return coord_t'(v - 100);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(COORD_W-1){1'b0}}};
          1: return {1'b0, {(COORD_W-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic void push_random_polygon(int n_pts);
    int      style, r;
    vertex_t v;
    r = $urandom_range(0, 99);
    style = (r < 40) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : 3;
    for (int i = 0; i < n_pts; i++) begin
      v.pos.x  = pick_coord(style);
      v.pos.y  = pick_coord(style);
      v.pos.z  = pick_coord(style);
      v.closes = (i == n_pts - 1);
      vertex_queue.insert(vertex_queue.size(), v);
    end
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin : vertex_driver
    vertex_t v;
    if (rst_ni && (!vtx_valid || vtx_taken)) begin
      if (vtx_gap > 0) begin
        vtx_gap--;
        vtx_valid <= 1'b0;
      end else if (vertex_queue.size() != 0) begin
        v = vertex_queue.pop_front();
        vtx_data  <= {{(IN_W-3*COORD_W){1'b0}}, v.pos.z, v.pos.y, v.pos.x};
        vtx_last  <= v.closes;
        vtx_valid <= 1'b1;
        vtx_gap   = steady ? 0 : pick_gap();
      end else begin
        vtx_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls plus one long hold-off while vertices keep coming
  always @(negedge clk_i) begin : result_sink
    if (rst_ni) begin
      if (sink_hold > 0) begin
        sink_hold--;
        res_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 12 && res_valid) begin
        long_hold_done = 1'b1;
        sink_hold = LONG_HOLD;
        res_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        sink_hold = pick_gap();
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    area_result_t got, want, nxt;
    vertex_t      v;
    if (rst_ni) begin
      vtx_taken <= vtx_valid && vtx_ready;
      // result side first: a result never belongs to a vertex taken on this edge
      if (res_valid && res_ready) begin
        got.area     = res_data[SUM_W-1:0];
        got.count    = res_data[SUM_W +: CNT_OUT_W];
        got.too_many = res_data[SUM_W+CNT_OUT_W];
        results_seen++;
        if (area_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual area %0d count %0d flag %0b",
                   $time, got.area, got.count, got.too_many);
        end else begin
          want = area_expected.pop_front();
          check_field("area_half_mm2", want.area, got.area);
          check_field("vertex_count", want.count, got.count);
          check_field("too_many", want.too_many, got.too_many);
        end
      end
      if (vtx_valid && vtx_ready) begin
        v.pos.x  = vtx_data[COORD_W-1:0];
        v.pos.y  = vtx_data[2*COORD_W-1:COORD_W];
        v.pos.z  = vtx_data[3*COORD_W-1:2*COORD_W];
        v.closes = vtx_last;
        vertices_in++;
        if (take_vertex(v, nxt)) area_expected.insert(area_expected.size(), nxt);
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : stimulus
    int r, n_pts;
    // lone vertex at the coordinate extremes
    push_pt(-524288, 524287, 0, 1'b1);
    // two vertices only
    push_pt(524287, -524288, 524287, 1'b0);
    push_pt(-1, 0, 1, 1'b1);
    // triangle spanning the full range
    push_pt(-524288, -524288, -524288, 1'b0);
    push_pt(524287, -524288, 524287, 1'b0);
    push_pt(-524288, 524287, 524287, 1'b1);
    // collinear points: zero area
    push_pt(0, 0, 0, 1'b0);
    push_pt(1, 1, 1, 1'b0);
    push_pt(2, 2, 2, 1'b1);
    // 1000 mm square in the xy plane
    push_pt(0, 0, 0, 1'b0);
    push_pt(1000, 0, 0, 1'b0);
    push_pt(1000, 1000, 0, 1'b0);
    push_pt(0, 1000, 0, 1'b1);
    // tilted pentagon with all-ones and small coordinates
    push_pt(-1, -1, -1, 1'b0);
    push_pt(300, -7, 12, 1'b0);
    push_pt(250, 400, -90, 1'b0);
    push_pt(-200, 350, 60, 1'b0);
    push_pt(-310, 20, -1, 1'b1);

    // vertex limit: exactly full, closing vertex dropped, several dropped
    push_random_polygon(MAX_VTX);
    push_random_polygon(MAX_VTX + 1);
    push_random_polygon(MAX_VTX + 6);
    while (vertex_queue.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) n_pts = $urandom_range(MAX_VTX - 2, MAX_VTX + 6);
      else if (r < 16) n_pts = $urandom_range(1, 2);
      else n_pts = $urandom_range(3, 12);
      push_random_polygon(n_pts);
    end
    total_queued = vertex_queue.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (vertices_in != total_queued || area_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d vertices in %0d polygons: %0d with fewer than three vertices,",
             vertices_in, polygons, thin_polygons);
    $display("%0d over the %0d-vertex limit, largest area %0d half mm^2, %0d results checked.",
             over_polygons, MAX_VTX, max_area, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("Timeout: %0d of %0d vertices taken, %0d results outstanding",
             vertices_in, total_queued, area_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
